// File: design/rbei_pkg.sv
// ----------------------------------------------------------------------------
// rbei_pkg - shared constants and helpers for the rigid body integrator
// Field widths, Q2.30 trig constants, CORDIC arctangent table, saturation.
// ----------------------------------------------------------------------------
package rbei_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DW            = 32;  // state and field width
  localparam int OW            = 34;  // multiplier operand width
  localparam int PW            = 2 * OW;  // product width
  localparam int SW            = PW + 2;  // sum width before saturation
  localparam int TS_W          = 17;
  localparam int GR_W          = 21;
  localparam int CFG_W         = 21;
  localparam int CFG_IDX_W     = 2;
  localparam int CORDIC_STEPS  = 30;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 2'd1;

  localparam logic [TS_W-1:0] TS_RESET = 17'd655;
  localparam logic [GR_W-1:0] GR_RESET = 21'd642689;

  localparam logic signed [63:0] Q30_PI       = 64'sd3373259426;
  localparam logic signed [63:0] Q30_HALF_PI  = 64'sd1686629713;
  localparam logic signed [63:0] Q30_TWO_PI   = 64'sd6746518852;
  localparam logic signed [OW-1:0] Q30_CORDIC_K = 34'sd652032874;

  function automatic logic signed [OW-1:0] atan_q30(input logic [4:0] i);
    logic signed [OW-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp to the 32-bit signed range
  function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] r;
    if (v > $signed({{(SW-DW){1'b0}}, 1'b0, {(DW-1){1'b1}}})) begin
      r = {1'b0, {(DW-1){1'b1}}};
    end else if (v < $signed({{(SW-DW){1'b1}}, 1'b1, {(DW-1){1'b0}}})) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/rigid_body_euler_integrator_top.sv
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator_top - multirotor Euler integrator (NED frame)
// Init beats load the pose; step beats integrate rates, rotate thrust, add
// gravity and, once airborne, integrate velocity and position, all on one shared multiplier.
// ----------------------------------------------------------------------------
// Order of work: an init beat loads the pose and goes straight to the
//   result; a step beat updates the angles, reduces each angle modulo 2pi
//   by restoring steps and runs 30 CORDIC iterations on it, forms the thrust
//   coefficients and accelerations, and only when airborne updates velocity
//   and position, all through one shared datapath. A new beat is taken only
//   back in idle, after any wait for the previous result beat to be taken.
// Reset: synchronous active-low rst_n clears pose, velocity, airborne flag
//   and output valid, and loads the default time step and gravity.
module rigid_body_euler_integrator_top #(
  parameter int FRAC_BITS = rbei_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rbei_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbei_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic signed [rbei_pkg::DW-1:0]      in_thrust,
  input  logic signed [rbei_pkg::DW-1:0]      in_roll_rate,
  input  logic signed [rbei_pkg::DW-1:0]      in_pitch_rate,
  input  logic signed [rbei_pkg::DW-1:0]      in_yaw_rate,
  input  logic signed [rbei_pkg::DW-1:0]      in_start_roll,
  input  logic signed [rbei_pkg::DW-1:0]      in_start_pitch,
  input  logic signed [rbei_pkg::DW-1:0]      in_start_yaw,
  input  logic signed [rbei_pkg::DW-1:0]      in_start_x,
  input  logic signed [rbei_pkg::DW-1:0]      in_start_y,
  input  logic signed [rbei_pkg::DW-1:0]      in_start_z,
  input  logic                                in_start_airborne,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rbei_pkg::DW-1:0]      out_roll,
  output logic signed [rbei_pkg::DW-1:0]      out_pitch,
  output logic signed [rbei_pkg::DW-1:0]      out_yaw,
  output logic signed [rbei_pkg::DW-1:0]      out_vel_x,
  output logic signed [rbei_pkg::DW-1:0]      out_vel_y,
  output logic signed [rbei_pkg::DW-1:0]      out_vel_z,
  output logic signed [rbei_pkg::DW-1:0]      out_pos_x,
  output logic signed [rbei_pkg::DW-1:0]      out_pos_y,
  output logic signed [rbei_pkg::DW-1:0]      out_pos_z,
  output logic                                out_is_airborne
);
  import rbei_pkg::*;

  // angle shift into Q2.30 and restoring steps needed to cover |a|
  localparam int ASH       = 30 - FRAC_BITS;
  localparam int RED_STEPS = 31 - FRAC_BITS;
  localparam int RKW       = $clog2(RED_STEPS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_WB, S_RINIT, S_RED, S_RFIX, S_CORD, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_ANG0, OP_ANG1, OP_ANG2,
    OP_T0, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_C2,
    OP_ACC0, OP_ACC1, OP_ACC2,
    OP_V0, OP_P0, OP_V1, OP_P1, OP_V2, OP_P2
  } op_t;

  state_t state_r;
  op_t    op_r;

  logic [TS_W-1:0] ts_r;
  logic [GR_W-1:0] gr_r;
  logic signed [DW-1:0] ang_r [3];
  logic signed [DW-1:0] vel_r [3];
  logic signed [DW-1:0] pos_r [3];
  logic signed [DW-1:0] acc_r [3];
  logic signed [DW-1:0] rate_r [3];
  logic signed [DW-1:0] thrust_r;
  logic                 air_r;

  logic signed [OW-1:0] sin_r [3];
  logic signed [OW-1:0] cos_r [3];
  logic signed [OW-1:0] coef_r [3];
  logic signed [OW-1:0] tmp_a_r, tmp_b_r;

  logic signed [PW-1:0] prod_r;
  logic signed [OW-1:0] opa, opb;

  // trig sequencer
  logic [1:0]           trig_idx_r;
  logic [RKW-1:0]       red_k_r;
  logic [4:0]           cord_i_r;
  logic [63:0]          rem_r;
  logic                 aneg_r;
  logic                 fold_r;
  logic signed [OW-1:0] cx_r, cy_r, cz_r;

  logic out_valid_r;
  logic signed [DW-1:0] out_ang_r [3];
  logic signed [DW-1:0] out_vel_r [3];
  logic signed [DW-1:0] out_pos_r [3];
  logic                 out_air_r;

  logic in_acc;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Operand select for the shared multiplier
  // --------------------------------------------------------------------------
  logic signed [OW-1:0] ts_op;
  assign ts_op = $signed({{(OW-TS_W){1'b0}}, ts_r});

  always_comb begin
    opa = '0;
    opb = '0;
    case (op_r)
      OP_ANG0: begin opa = ts_op; opb = OW'(rate_r[0]); end
      OP_ANG1: begin opa = ts_op; opb = OW'(rate_r[1]); end
      OP_ANG2: begin opa = ts_op; opb = OW'(rate_r[2]); end
      OP_T0:   begin opa = sin_r[0]; opb = sin_r[2]; end
      OP_T1:   begin opa = cos_r[0]; opb = cos_r[2]; end
      OP_T2:   begin opa = tmp_b_r;  opb = sin_r[1]; end
      OP_T3:   begin opa = cos_r[0]; opb = sin_r[2]; end
      OP_T4:   begin opa = tmp_a_r;  opb = sin_r[1]; end
      OP_T5:   begin opa = cos_r[2]; opb = sin_r[0]; end
      OP_C2:   begin opa = cos_r[0]; opb = cos_r[1]; end
      OP_ACC0: begin opa = OW'(thrust_r); opb = coef_r[0]; end
      OP_ACC1: begin opa = OW'(thrust_r); opb = coef_r[1]; end
      OP_ACC2: begin opa = OW'(thrust_r); opb = coef_r[2]; end
      OP_V0:   begin opa = ts_op; opb = OW'(acc_r[0]); end
      OP_V1:   begin opa = ts_op; opb = OW'(acc_r[1]); end
      OP_V2:   begin opa = ts_op; opb = OW'(acc_r[2]); end
      OP_P0:   begin opa = ts_op; opb = OW'(vel_r[0]); end
      OP_P1:   begin opa = ts_op; opb = OW'(vel_r[1]); end
      OP_P2:   begin opa = ts_op; opb = OW'(vel_r[2]); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // round half up back to Q30 or Q(F)
  logic signed [PW-1:0] r30, rf;
  logic signed [SW-1:0] neg30_ext, acc_sum;
  logic signed [DW-1:0] acc_neg, acc_g;
  assign r30 = (prod_r + (PW'(1) <<< 29)) >>> 30;
  assign rf  = (prod_r + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign neg30_ext = -SW'(r30);
  assign acc_neg   = sat32(neg30_ext);
  assign acc_sum   = SW'(acc_neg) + $signed({{(SW-GR_W){1'b0}}, gr_r});
  assign acc_g     = sat32(acc_sum);

  function automatic logic signed [DW-1:0] acc_add(input logic signed [DW-1:0] s,
                                                   input logic signed [PW-1:0] d);
    return sat32(SW'(s) + SW'(d));
  endfunction

  // --------------------------------------------------------------------------
  // Range reduction and CORDIC datapath
  // --------------------------------------------------------------------------
  logic signed [63:0]   a_ext;
  logic [63:0]          a_mag;
  logic [63:0]          red_cmp;
  logic signed [63:0]   fix0, fix1, fix2;
  logic                 fold_nxt;
  logic signed [OW-1:0] dxs, dys, at;
  logic signed [OW-1:0] cx_nxt, cy_nxt, cz_nxt;

  assign a_ext   = 64'(ang_r[trig_idx_r]) <<< ASH;
  assign a_mag   = a_ext[63] ? 64'(-a_ext) : 64'(a_ext);
  assign red_cmp = 64'(Q30_TWO_PI) << red_k_r;

  always_comb begin
    fix0 = (aneg_r && (rem_r != '0)) ? (Q30_TWO_PI - $signed(rem_r)) : $signed(rem_r);
    fix1 = (fix0 >= Q30_PI) ? (fix0 - Q30_TWO_PI) : fix0;
    fold_nxt = 1'b0;
    if (fix1 > Q30_HALF_PI) begin
      fix2 = fix1 - Q30_PI;
      fold_nxt = 1'b1;
    end else if (fix1 < -Q30_HALF_PI) begin
      fix2 = fix1 + Q30_PI;
      fold_nxt = 1'b1;
    end else begin
      fix2 = fix1;
    end
  end

  assign dxs = cy_r >>> cord_i_r;
  assign dys = cx_r >>> cord_i_r;
  assign at  = atan_q30(cord_i_r);

  always_comb begin
    if (!cz_r[OW-1]) begin
      cx_nxt = cx_r - dxs;
      cy_nxt = cy_r + dys;
      cz_nxt = cz_r - at;
    end else begin
      cx_nxt = cx_r + dxs;
      cy_nxt = cy_r - dys;
      cz_nxt = cz_r + at;
    end
  end

  logic air_nxt;
  assign air_nxt = air_r || acc_g[DW-1];

  // where the sequencer goes after a write-back
  state_t wb_state_nxt;
  always_comb begin
    case (op_r)
      OP_ANG2: wb_state_nxt = S_RINIT;
      OP_ACC2: wb_state_nxt = air_nxt ? S_MUL : S_DONE;
      OP_P2:   wb_state_nxt = S_DONE;
      default: wb_state_nxt = S_MUL;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer, state and output registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ANG0;
      out_valid_r <= 1'b0;
      ts_r        <= TS_RESET;
      gr_r        <= GR_RESET;
      air_r       <= 1'b0;
      trig_idx_r  <= '0;
      red_k_r     <= '0;
      cord_i_r    <= '0;
      for (int j = 0; j < 3; j++) begin
        ang_r[j] <= '0;
        vel_r[j] <= '0;
        pos_r[j] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP: ts_r <= cfg_wdata[TS_W-1:0];
          REG_GRAVITY:   gr_r <= cfg_wdata[GR_W-1:0];
          default: ;
        endcase
      end
      // drop the result beat once taken, unless a new one loads this cycle
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!in_action) begin
              ang_r[0] <= in_start_roll;
              ang_r[1] <= in_start_pitch;
              ang_r[2] <= in_start_yaw;
              pos_r[0] <= in_start_x;
              pos_r[1] <= in_start_y;
              pos_r[2] <= in_start_z;
              for (int j = 0; j < 3; j++) vel_r[j] <= '0;
              air_r   <= in_start_airborne;
              state_r <= S_DONE;
            end else begin
              thrust_r  <= in_thrust;
              rate_r[0] <= in_roll_rate;
              rate_r[1] <= in_pitch_rate;
              rate_r[2] <= in_yaw_rate;
              op_r      <= OP_ANG0;
              state_r   <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod_r  <= PW'(opa) * PW'(opb);
          state_r <= S_WB;
        end

        S_WB: begin
          state_r <= wb_state_nxt;
          op_r    <= op_t'(op_r + 5'd1);
          case (op_r)
            OP_ANG0: ang_r[0] <= acc_add(ang_r[0], rf);
            OP_ANG1: ang_r[1] <= acc_add(ang_r[1], rf);
            OP_ANG2: begin
              ang_r[2]   <= acc_add(ang_r[2], rf);
              trig_idx_r <= '0;
            end
            OP_T0: tmp_a_r   <= r30[OW-1:0];
            OP_T1: tmp_b_r   <= r30[OW-1:0];
            OP_T2: coef_r[0] <= tmp_a_r + r30[OW-1:0];
            OP_T3: tmp_a_r   <= r30[OW-1:0];
            OP_T4: tmp_b_r   <= r30[OW-1:0];
            OP_T5: coef_r[1] <= tmp_b_r - r30[OW-1:0];
            OP_C2: coef_r[2] <= r30[OW-1:0];
            OP_ACC0: acc_r[0] <= acc_neg;
            OP_ACC1: acc_r[1] <= acc_neg;
            OP_ACC2: begin
              // latch airborne once net down acceleration goes negative
              acc_r[2] <= acc_g;
              air_r    <= air_nxt;
            end
            OP_V0: vel_r[0] <= acc_add(vel_r[0], rf);
            OP_V1: vel_r[1] <= acc_add(vel_r[1], rf);
            OP_V2: vel_r[2] <= acc_add(vel_r[2], rf);
            OP_P0: pos_r[0] <= acc_add(pos_r[0], rf);
            OP_P1: pos_r[1] <= acc_add(pos_r[1], rf);
            OP_P2: pos_r[2] <= acc_add(pos_r[2], rf);
            default: ;
          endcase
        end

        S_RINIT: begin
          // magnitude of the Q2.30 angle, reduced below 2pi by restoring steps
          rem_r   <= a_mag;
          aneg_r  <= a_ext[63];
          red_k_r <= RKW'(RED_STEPS - 1);
          state_r <= S_RED;
        end

        S_RED: begin
          if (rem_r >= red_cmp) rem_r <= rem_r - red_cmp;
          if (red_k_r == '0) begin
            state_r <= S_RFIX;
          end else begin
            red_k_r <= red_k_r - RKW'(1);
          end
        end

        S_RFIX: begin
          cz_r     <= fix2[OW-1:0];
          cx_r     <= Q30_CORDIC_K;
          cy_r     <= '0;
          fold_r   <= fold_nxt;
          cord_i_r <= '0;
          state_r  <= S_CORD;
        end

        S_CORD: begin
          cx_r     <= cx_nxt;
          cy_r     <= cy_nxt;
          cz_r     <= cz_nxt;
          cord_i_r <= cord_i_r + 5'd1;
          if (cord_i_r == 5'(CORDIC_STEPS - 1)) begin
            sin_r[trig_idx_r] <= fold_r ? -cy_nxt : cy_nxt;
            cos_r[trig_idx_r] <= fold_r ? -cx_nxt : cx_nxt;
            if (trig_idx_r == 2'd2) begin
              op_r    <= OP_T0;
              state_r <= S_MUL;
            end else begin
              trig_idx_r <= trig_idx_r + 2'd1;
              state_r    <= S_RINIT;
            end
          end
        end

        S_DONE: begin
          // hold until the previous result beat has drained
          if (!out_valid_r || out_ready) begin
            for (int j = 0; j < 3; j++) begin
              out_ang_r[j] <= ang_r[j];
              out_vel_r[j] <= vel_r[j];
              out_pos_r[j] <= pos_r[j];
            end
            out_air_r   <= air_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll        = out_ang_r[0];
  assign out_pitch       = out_ang_r[1];
  assign out_yaw         = out_ang_r[2];
  assign out_vel_x       = out_vel_r[0];
  assign out_vel_y       = out_vel_r[1];
  assign out_vel_z       = out_vel_r[2];
  assign out_pos_x       = out_pos_r[0];
  assign out_pos_y       = out_pos_r[1];
  assign out_pos_z       = out_pos_r[2];
  assign out_is_airborne = out_air_r;

`ifndef SYNTHESIS
  a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_action) |=> (state_r == S_MUL && op_r == OP_ANG0))
    else $error("step beat did not start the angle update");

  a_air_falls_on_init: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(air_r) |-> $past(in_acc && !in_action))
    else $error("airborne flag dropped without an init beat");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORD) |-> (cord_i_r < 5'(CORDIC_STEPS)))
    else $error("CORDIC iteration count overran");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_ready)) |=>
      (out_valid_r && out_air_r == air_r))
    else $error("result beat not loaded at completion");
`endif

endmodule

// File: bench/tb_rigid_body_euler_integrator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rigid_body_euler_integrator_top - pose integrator self-checking bench
// Drives init and step beats with random idling on both channels. A local
// fixed-point predictor holds its own pose, velocity and flight state, and
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_rigid_body_euler_integrator_top;
  import rbei_pkg::*;

  localparam int F         = 16;
  localparam int QUIET_MAX = 20000;  // cycles with no beat before giving up
  localparam int DRAIN     = 400;    // cycles of settling after the last result
  localparam int N_RAND    = 1700;

  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic signed [63:0] KX = 64'sd652032874;
  localparam logic signed [31:0] MAXP = 32'sh7fffffff;
  localparam logic signed [31:0] MINN = 32'sh80000000;

  typedef struct packed {
    logic               action;
    logic signed [31:0] thrust, rr, pr, yr;
    logic signed [31:0] sroll, spitch, syaw, sx, sy, sz;
    logic               sair;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] roll, pitch, yaw;
    logic signed [31:0] vx, vy, vz, px, py, pz;
    logic               air;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  cmd_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pose_t got;

  cmd_t  pending[$];
  pose_t predicted[$];
  int    errors = 0;
  int    quiet = 0;
  bit    calm = 1'b0;     // last part of the run: no idling
  int    in_hold = 0, out_hold = 0;
  bit    in_taken = 1'b0;

  // predictor state
  logic [16:0] p_dt = 17'd655;
  logic [20:0] p_grav = 21'd642689;
  logic signed [31:0] p_ang[3], p_vel[3], p_pos[3];
  logic p_air = 1'b0;
  logic signed [63:0] atan_tab[30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  rigid_body_euler_integrator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(cur.action), .in_thrust(cur.thrust),
    .in_roll_rate(cur.rr), .in_pitch_rate(cur.pr), .in_yaw_rate(cur.yr),
    .in_start_roll(cur.sroll), .in_start_pitch(cur.spitch),
    .in_start_yaw(cur.syaw), .in_start_x(cur.sx), .in_start_y(cur.sy),
    .in_start_z(cur.sz), .in_start_airborne(cur.sair),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll(got.roll), .out_pitch(got.pitch), .out_yaw(got.yaw),
    .out_vel_x(got.vx), .out_vel_y(got.vy), .out_vel_z(got.vz),
    .out_pos_x(got.px), .out_pos_y(got.py), .out_pos_z(got.pz),
    .out_is_airborne(got.air)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // >>> with arithmetic on a signed 64-bit value is a floor shift
  function automatic logic signed [63:0] rnd(logic signed [63:0] p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [63:0] v);
    if (v > 64'(MAXP)) return MAXP;
    if (v < 64'(MINN)) return MINN;
    return v[31:0];
  endfunction

  task automatic trig(input logic signed [31:0] ang,
                      output logic signed [63:0] sn, output logic signed [63:0] cs);
    logic signed [63:0] a, x, y, z, dx, dy;
    bit flip;
    a = 64'(ang) <<< (30 - F);
    a = a % Q30_TWO_PI;
    if (a < 0) a += Q30_TWO_PI;
    if (a >= Q30_PI) a -= Q30_TWO_PI;
    flip = 1'b0;
    if (a > Q30_HALF_PI) begin
      a -= Q30_PI;
      flip = 1'b1;
    end else if (a < -Q30_HALF_PI) begin
      a += Q30_PI;
      flip = 1'b1;
    end
    x = KX;
    y = 0;
    z = a;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // advance the predicted pose by one beat and queue the expected result
  task automatic predict_pose(input cmd_t c);
    logic signed [63:0] sr, cr, sp, cp, sw, cw, dt, fz;
    logic signed [63:0] coef[3];
    logic signed [31:0] acc[3], rates[3];
    pose_t e;
    dt = 64'(p_dt);
    if (c.action == ACT_INIT) begin
      p_ang = '{c.sroll, c.spitch, c.syaw};
      p_pos = '{c.sx, c.sy, c.sz};
      p_vel = '{0, 0, 0};
      p_air = c.sair;
    end else begin
      rates = '{c.rr, c.pr, c.yr};
      for (int j = 0; j < 3; j++)
        p_ang[j] = clamp(64'(p_ang[j]) + rnd(dt * 64'(rates[j]), F));
      trig(p_ang[0], sr, cr);
      trig(p_ang[1], sp, cp);
      trig(p_ang[2], sw, cw);
      coef[0] = rnd(sr * sw, 30) + rnd(rnd(cr * cw, 30) * sp, 30);
      coef[1] = rnd(rnd(cr * sw, 30) * sp, 30) - rnd(cw * sr, 30);
      coef[2] = rnd(cr * cp, 30);
      fz = 64'(c.thrust);
      for (int j = 0; j < 3; j++) acc[j] = clamp(-rnd(fz * coef[j], 30));
      acc[2] = clamp(64'(acc[2]) + 64'(p_grav));
      if (!p_air) p_air = acc[2] < 0;
      if (p_air) begin
        for (int j = 0; j < 3; j++) begin
          p_vel[j] = clamp(64'(p_vel[j]) + rnd(dt * 64'(acc[j]), F));
          p_pos[j] = clamp(64'(p_pos[j]) + rnd(dt * 64'(p_vel[j]), F));
        end
      end
    end
    e.roll = p_ang[0]; e.pitch = p_ang[1]; e.yaw = p_ang[2];
    e.vx = p_vel[0]; e.vy = p_vel[1]; e.vz = p_vel[2];
    e.px = p_pos[0]; e.py = p_pos[1]; e.pz = p_pos[2];
    e.air = p_air;
    predicted.push_back(e);
  endtask

  task automatic report(input string what, input logic [31:0] g, input logic [31:0] w);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, g, w, $realtime);
  endtask

  // driver: present the next beat at the falling edge, idle in bursts
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_hold > 0) begin
        in_hold <= in_hold - 1;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_hold <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (pending.size() > 0 && rst_n) begin
        cur <= pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      out_hold <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (in_valid && in_ready) begin
        predict_pose(cur);
      end
      if (out_valid && out_ready) begin
        if (predicted.size() == 0) begin
          report("unexpected beat", '0, '0);
        end else begin
          pose_t w;
          w = predicted.pop_front();
          if (got.roll !== w.roll) report("roll", got.roll, w.roll);
          if (got.pitch !== w.pitch) report("pitch", got.pitch, w.pitch);
          if (got.yaw !== w.yaw) report("yaw", got.yaw, w.yaw);
          if (got.vx !== w.vx) report("vel_x", got.vx, w.vx);
          if (got.vy !== w.vy) report("vel_y", got.vy, w.vy);
          if (got.vz !== w.vz) report("vel_z", got.vz, w.vz);
          if (got.px !== w.px) report("pos_x", got.px, w.px);
          if (got.py !== w.py) report("pos_y", got.py, w.py);
          if (got.pz !== w.pz) report("pos_z", got.pz, w.pz);
          if (got.air !== w.air) report("is_airborne", 32'(got.air), 32'(w.air));
        end
      end
      if (quiet >= QUIET_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return MAXP;
      1: return MINN;
      2: return $signed($urandom_range(0, 400000)) - 200000;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_t make_init(bit wild);
    cmd_t c;
    c = '0;
    c.action = ACT_INIT;
    c.thrust = $urandom(); c.rr = $urandom(); c.pr = $urandom(); c.yr = $urandom();
    c.sroll = wild ? rnd_word() : $signed($urandom_range(0, 800000)) - 400000;
    c.spitch = wild ? rnd_word() : $signed($urandom_range(0, 200000)) - 100000;
    c.syaw = wild ? rnd_word() : $urandom();
    c.sx = rnd_word(); c.sy = rnd_word(); c.sz = rnd_word();
    c.sair = $urandom_range(0, 1);
    return c;
  endfunction

  function automatic cmd_t make_step(bit wild);
    cmd_t c;
    c = '0;
    c.action = ACT_STEP;
    // mostly lift near hover weight so the vehicle takes off and flies
    c.thrust = wild ? rnd_word() : -($signed($urandom_range(0, 1600000)));
    c.rr = wild ? rnd_word() : $signed($urandom_range(0, 400000)) - 200000;
    c.pr = wild ? rnd_word() : $signed($urandom_range(0, 400000)) - 200000;
    c.yr = wild ? rnd_word() : $signed($urandom_range(0, 400000)) - 200000;
    c.sroll = $urandom(); c.spitch = $urandom(); c.syaw = $urandom();
    c.sx = $urandom(); c.sy = $urandom(); c.sz = $urandom();
    c.sair = $urandom_range(0, 1);
    return c;
  endfunction

  // write one register; the block is idle whenever this is called
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TIME_STEP) p_dt = v[16:0];
    else if (idx == REG_GRAVITY) p_grav = v[20:0];
  endtask

  // hold off until the block has returned everything and gone quiet
  task automatic settle();
    while (pending.size() > 0 || in_valid || predicted.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    cmd_t c;
    p_ang = '{0, 0, 0};
    p_vel = '{0, 0, 0};
    p_pos = '{0, 0, 0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults, extremes of every field, both actions
    c = make_init(1'b0);
    c.sroll = MAXP; c.spitch = MINN; c.syaw = 0; c.sair = 1'b0;
    pending.push_back(c);
    c = make_step(1'b0); c.thrust = 0; pending.push_back(c);         // grounded
    c = make_step(1'b0); c.thrust = MINN; pending.push_back(c);      // lift off
    c = make_step(1'b0); c.thrust = MAXP; c.rr = MAXP; c.pr = MINN;
    c.yr = MAXP; pending.push_back(c);                               // saturate angles
    c = make_step(1'b0); c.rr = MAXP; c.pr = MAXP; c.yr = MINN; pending.push_back(c);
    c = make_init(1'b1); c.sx = MAXP; c.sy = MINN; c.sz = MAXP; c.sair = 1'b1;
    pending.push_back(c);
    c = make_step(1'b0); c.thrust = MINN; pending.push_back(c);
    c = make_step(1'b0); c.thrust = MAXP; pending.push_back(c);
    c = make_init(1'b0); c.sx = '1; c.sy = '1; c.sz = '1; c.sroll = '1;
    c.spitch = '1; c.syaw = '1; c.sair = 1'b1; pending.push_back(c);
    c = make_step(1'b0); c.thrust = '1; c.rr = '1; c.pr = '1; c.yr = '1;
    pending.push_back(c);
    settle();

    // extreme settings: large step and gravity, out-of-range indices, then zero
    write_reg(REG_TIME_STEP, 21'd65536);
    write_reg(REG_GRAVITY, 21'd2000000);
    write_reg(2'd3, 21'h1fffff);
    write_reg(2'd2, 21'h0);
    for (int k = 0; k < 12; k++)
      pending.push_back(k % 5 == 0 ? make_init(1'b1) : make_step(k % 3 == 0));
    settle();
    write_reg(REG_TIME_STEP, 21'd0);
    write_reg(REG_GRAVITY, 21'd0);
    for (int k = 0; k < 8; k++)
      pending.push_back(k == 0 ? make_init(1'b0) : make_step(1'b1));
    settle();

    // random phases; each starts with a pose load, then mostly sane flight
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        write_reg(REG_TIME_STEP, ph == 5 ? 21'd655 : 21'($urandom_range(0, 65536)));
        write_reg(REG_GRAVITY, ph == 5 ? 21'd642689 : 21'($urandom_range(0, 2000000)));
      end
      calm = (ph == 5);
      for (int k = 0; k < N_RAND / 6; k++) begin
        if (k % 60 == 0) pending.push_back(make_init($urandom_range(0, 3) == 0));
        else if ($urandom_range(0, 15) == 0) pending.push_back(make_init(1'b1));
        else pending.push_back(make_step($urandom_range(0, 9) == 0));
      end
      settle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: rigid_body_euler_integrator_top.f
design/rbei_pkg.sv
design/rigid_body_euler_integrator_top.sv
bench/tb_rigid_body_euler_integrator_top.sv
